@@ rtl/core/fsme_pkg.sv @@
`default_nettype none

package fsme_pkg;

    // fixed field widths
    localparam int KIND_W   = 1;
    localparam int MACH_W   = 5;
    localparam int JOB_W    = 8;
    localparam int PTIME_W  = 16;
    localparam int COMP_W   = 30;
    localparam int IDLE_W   = 36;
    localparam int NMACH_W  = 6;

    localparam logic [COMP_W-1:0]  COMP_MAX = {COMP_W{1'b1}};
    localparam logic [IDLE_W-1:0]  IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [NMACH_W-1:0] NUM_MACHINES_RST = NMACH_W'(32);

    // parameter defaults
    localparam int DEF_MAX_MACHINES = 32;
    localparam int DEF_MAX_JOBS     = 256;
    localparam int DEF_TIME_BITS    = 16;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_JOB   = 1'b1;

    // request moving down the machine chain
    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [MACH_W-1:0]   mach;
        logic [JOB_W-1:0]    job;
        logic                job_ok;
        logic [PTIME_W-1:0]  ptime;
        logic                last;
        logic [COMP_W-1:0]   prev;  // completion on the machine upstream
        logic [IDLE_W-1:0]   idle;  // idle gathered by this job so far
    } t_token;

endpackage

`default_nettype wire

@@ rtl/core/fsme_cell.sv @@
`default_nettype none

module fsme_cell
    import fsme_pkg::*;
#(
    parameter int CELL_IDX  = 0,
    parameter int MAX_JOBS  = DEF_MAX_JOBS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_active,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    localparam int JOB_AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int SUM_W  = ((COMP_W > TIME_BITS) ? COMP_W : TIME_BITS) + 1;

    logic [TIME_BITS-1:0] mem [MAX_JOBS];
    logic [TIME_BITS-1:0] r_rdata;
    t_token               r_s1;
    t_token               r_s2;
    t_token               n_s2;
    logic [COMP_W-1:0]    r_c;
    logic [COMP_W-1:0]    n_c;

    logic [JOB_AW-1:0]    w_addr;
    logic                 w_wr;
    logic [TIME_BITS-1:0] w_time;
    logic                 w_job;
    logic                 w_late;
    logic [COMP_W-1:0]    w_start;
    logic [COMP_W-1:0]    w_gap;
    logic [SUM_W-1:0]     w_sum;
    logic [COMP_W-1:0]    w_newc;
    logic [IDLE_W:0]      w_isum;
    logic [IDLE_W-1:0]    w_nidle;

    assign w_addr = JOB_AW'(i_tok.job);
    assign w_wr   = i_adv && i_tok.valid && (i_tok.kind == KIND_WRITE) && i_tok.job_ok
                    && (int'(i_tok.mach) == CELL_IDX);

    // this machine's column of the time table
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_addr] <= TIME_BITS'(i_tok.ptime);
        end
        if (i_adv) begin
            r_rdata <= mem[w_addr];
        end
    end

    always_comb begin
        w_time  = r_s1.job_ok ? r_rdata : '0;
        w_job   = r_s1.valid && (r_s1.kind == KIND_JOB);
        w_late  = r_s1.prev > r_c;
        w_start = w_late ? r_s1.prev : r_c;
        w_gap   = w_late ? (r_s1.prev - r_c) : '0;
        w_sum   = SUM_W'(w_start) + SUM_W'(w_time);
        w_newc  = (w_sum > SUM_W'(COMP_MAX)) ? COMP_MAX : COMP_W'(w_sum);
        w_isum  = {1'b0, r_s1.idle} + (IDLE_W + 1)'(w_gap);
        w_nidle = w_isum[IDLE_W] ? IDLE_MAX : w_isum[IDLE_W-1:0];

        n_s2 = r_s1;
        n_c  = r_c;
        if (w_job && i_active) begin
            n_s2.prev = w_newc;
            n_s2.idle = w_nidle;
            n_c       = w_newc;
        end
        if (w_job && r_s1.last) begin
            n_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_c        <= '0;
        end else if (i_adv) begin
            r_s1 <= i_tok;
            r_s2 <= n_s2;
            r_c  <= n_c;
        end
    end

    assign o_tok = r_s2;

endmodule

`default_nettype wire

@@ rtl/core/flow_shop_makespan_eval_top.sv @@
`default_nettype none

// Permutation flow-shop makespan evaluator. Requests flow down a chain of
// MAX_MACHINES cells, one per machine; each cell keeps its machine's completion
// time and its own column of the processing-time table (MAX_JOBS entries).
// A table write (kind 0) updates the column of its machine as it passes; a job
// (kind 1) advances every active machine as it passes, and a job marked last
// yields one result (makespan, total idle) and clears the schedule. One request
// is taken per cycle unless the chain holds; each cell reads its table, then
// updates; the result is registered after the last cell. The whole chain holds
// while a result waits at the output. num_machines below 2 acts as 2, above
// MAX_MACHINES as MAX_MACHINES; change it only when no request is in flight.

module flow_shop_makespan_eval_top
    import fsme_pkg::*;
#(
    parameter int MAX_MACHINES = DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = DEF_MAX_JOBS,
    parameter int TIME_BITS    = DEF_TIME_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [NMACH_W-1:0] i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [MACH_W-1:0]  i_machine_index,
    input  wire logic [JOB_W-1:0]   i_job_index,
    input  wire logic [PTIME_W-1:0] i_proc_time,
    input  wire logic               i_last_job,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [COMP_W-1:0]       o_makespan,
    output logic [IDLE_W-1:0]       o_idle_total
);

    localparam int MCNT_W = $clog2(MAX_MACHINES + 1);

    logic [NMACH_W-1:0] r_num;
    logic [MCNT_W-1:0]  w_m;
    logic               w_adv;
    logic [MAX_MACHINES-1:0] w_active;
    t_token             w_tok [MAX_MACHINES+1];
    t_token             w_end;

    logic [IDLE_W-1:0]  r_idle_acc;
    logic [IDLE_W:0]    w_isum;
    logic [IDLE_W-1:0]  w_idle;
    logic               r_out_valid;
    logic [COMP_W-1:0]  r_makespan;
    logic [IDLE_W-1:0]  r_idle_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_MACHINES_RST;
        end else if (i_cfg_valid) begin
            r_num <= i_cfg_data;
        end
    end

    always_comb begin
        if (int'(r_num) < 2) begin
            w_m = MCNT_W'(2);
        end else if (int'(r_num) > MAX_MACHINES) begin
            w_m = MCNT_W'(MAX_MACHINES);
        end else begin
            w_m = MCNT_W'(r_num);
        end
    end

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_comb begin
        w_tok[0].valid  = i_in_valid;
        w_tok[0].kind   = i_kind;
        w_tok[0].mach   = i_machine_index;
        w_tok[0].job    = i_job_index;
        w_tok[0].job_ok = int'(i_job_index) < MAX_JOBS;
        w_tok[0].ptime  = i_proc_time;
        w_tok[0].last   = i_last_job;
        w_tok[0].prev   = '0;
        w_tok[0].idle   = '0;
    end

    for (genvar k = 0; k < MAX_MACHINES; k++) begin : g_cell
        assign w_active[k] = int'(w_m) > k;

        fsme_cell #(
            .CELL_IDX  (k),
            .MAX_JOBS  (MAX_JOBS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_active (w_active[k]),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    assign w_end  = w_tok[MAX_MACHINES];
    assign w_isum = {1'b0, r_idle_acc} + {1'b0, w_end.idle};
    assign w_idle = w_isum[IDLE_W] ? IDLE_MAX : w_isum[IDLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_acc  <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_end.valid && (w_end.kind == KIND_JOB) && w_end.last;
            if (w_end.valid && (w_end.kind == KIND_JOB)) begin
                r_idle_acc <= w_end.last ? '0 : w_idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_makespan <= w_end.prev;
            r_idle_out <= w_idle;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_makespan   = r_makespan;
    assign o_idle_total = r_idle_out;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
module tb_top
    import fsme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 80;    // longer than one pass down the chain
    localparam int HOLD_CYCLES   = 500;
    localparam int QUIET_LIMIT   = 4000;
    localparam int NM            = DEF_MAX_MACHINES;
    localparam int NJ            = DEF_MAX_JOBS;

    typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind               what;
        logic [KIND_W-1:0]      kind;
        logic [MACH_W-1:0]      mach;
        logic [JOB_W-1:0]       job;
        logic [PTIME_W-1:0]     ptime;
        logic                   last;
        logic [NMACH_W-1:0]     cfg;
    } t_shop_op;

    typedef struct {
        logic [COMP_W-1:0] makespan;
        logic [IDLE_W-1:0] idle;
    } t_span;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [NMACH_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind_r = '0;
    logic [MACH_W-1:0]   mach_r = '0;
    logic [JOB_W-1:0]    job_r = '0;
    logic [PTIME_W-1:0]  ptime_r = '0;
    logic                last_r = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [COMP_W-1:0]   makespan;
    logic [IDLE_W-1:0]   idle_total;

    // pending requests, and the spans the schedule is due to report
    t_shop_op shop_ops[$];
    t_span    due_spans[$];

    // schedule state as the block should hold it
    logic [PTIME_W-1:0]  time_tab [NM][NJ];
    logic [COMP_W-1:0]   comp_row [NM];
    logic [IDLE_W-1:0]   idle_sum = '0;
    logic [NMACH_W-1:0]  mach_cnt = NUM_MACHINES_RST;

    // generation side: entries written so far and machines active
    bit gen_written [NM][NJ];
    int gen_active = NM;
    int n_items = 0;

    int fail_cnt = 0;
    int snd_streak = 0;
    int rcv_streak = 0;
    int quiet_cycles = 0;

    flow_shop_makespan_eval_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind_r),
        .i_machine_index (mach_r),
        .i_job_index     (job_r),
        .i_proc_time     (ptime_r),
        .i_last_job      (last_r),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_makespan      (makespan),
        .o_idle_total    (idle_total)
    );

    always #6 clk = ~clk;

    function automatic int active_count(logic [NMACH_W-1:0] v);
        if (v < 2) return 2;
        if (v > NM) return NM;
        return int'(v);
    endfunction

    function automatic logic [COMP_W-1:0] sat_comp(logic [COMP_W-1:0] a,
                                                   logic [PTIME_W-1:0] t);
        logic [COMP_W:0] s;
        s = {1'b0, a} + (COMP_W+1)'(t);
        return s[COMP_W] ? COMP_MAX : s[COMP_W-1:0];
    endfunction

    function automatic void advance_schedule(t_shop_op op);
        int m;
        logic [IDLE_W:0] isum;
        t_span done;
        if (op.kind == KIND_WRITE) begin
            time_tab[op.mach][op.job] = op.ptime;
            return;
        end
        m = active_count(mach_cnt);
        comp_row[0] = sat_comp(comp_row[0], time_tab[0][op.job]);
        for (int k = 1; k < m; k++) begin
            if (comp_row[k-1] > comp_row[k]) begin
                isum = {1'b0, idle_sum} + (IDLE_W+1)'(comp_row[k-1] - comp_row[k]);
                idle_sum = isum[IDLE_W] ? IDLE_MAX : isum[IDLE_W-1:0];
                comp_row[k] = sat_comp(comp_row[k-1], time_tab[k][op.job]);
            end else begin
                comp_row[k] = sat_comp(comp_row[k], time_tab[k][op.job]);
            end
        end
        if (op.last) begin
            done.makespan = comp_row[m-1];
            done.idle = idle_sum;
            due_spans.push_back(done);
            foreach (comp_row[k])
                comp_row[k] = '0;
            idle_sum = '0;
        end
    endfunction

    function automatic int draw_gap(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [PTIME_W-1:0] rand_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return PTIME_W'($urandom_range(0, 15));
            default: return PTIME_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_write(int m, int j, logic [PTIME_W-1:0] t, bit last);
        t_shop_op op;
        op.what = OP_REQ;
        op.kind = KIND_WRITE;
        op.mach = MACH_W'(m);
        op.job = JOB_W'(j);
        op.ptime = t;
        op.last = last;
        op.cfg = '0;
        shop_ops.push_back(op);
        gen_written[m][j] = 1'b1;
        n_items++;
    endfunction

    // machine_index and proc_time are don't-care on a job, so they get noise
    function automatic void add_job(int j, bit last);
        t_shop_op op;
        op.what = OP_REQ;
        op.kind = KIND_JOB;
        op.mach = MACH_W'($urandom_range(0, 31));
        op.job = JOB_W'(j);
        op.ptime = PTIME_W'($urandom_range(0, 65535));
        op.last = last;
        op.cfg = '0;
        shop_ops.push_back(op);
        n_items++;
    endfunction

    // never schedule a job that would read an unwritten table entry
    function automatic void add_ready_job(int j, bit last);
        for (int k = 0; k < gen_active; k++)
            if (!gen_written[k][j])
                add_write(k, j, rand_time(), 1'($urandom_range(0, 1)));
        add_job(j, last);
    endfunction

    function automatic void add_drain();
        t_shop_op op;
        op.what = OP_DRAIN;
        op.kind = KIND_WRITE;
        op.mach = '0;
        op.job = '0;
        op.ptime = '0;
        op.last = 1'b0;
        op.cfg = '0;
        shop_ops.push_back(op);
    endfunction

    function automatic void add_cfg(logic [NMACH_W-1:0] v);
        t_shop_op op;
        add_drain();
        op.what = OP_CFG;
        op.kind = KIND_WRITE;
        op.mach = '0;
        op.job = '0;
        op.ptime = '0;
        op.last = 1'b0;
        op.cfg = v;
        shop_ops.push_back(op);
        gen_active = active_count(v);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fail_cnt < 40)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_cnt++;
    endtask

    initial begin
        foreach (comp_row[k])
            comp_row[k] = '0;
    end

    always @(posedge clk) begin : drive_proc
        t_shop_op cur_op;
        int gap_left;
        int settle;
        logic nv_in;
        logic nv_cfg;
        if (!rst_n) begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            settle = 0;
        end else begin
            if (in_valid && in_ready)
                advance_schedule(cur_op);
            if (cfg_valid && cfg_ready)
                mach_cnt = cfg_data;
            nv_in = in_valid && !in_ready;
            nv_cfg = cfg_valid && !cfg_ready;
            if (!nv_in && !nv_cfg && shop_ops.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    case (shop_ops[0].what)
                        OP_REQ: begin
                            cur_op = shop_ops.pop_front();
                            kind_r <= cur_op.kind;
                            mach_r <= cur_op.mach;
                            job_r <= cur_op.job;
                            ptime_r <= cur_op.ptime;
                            last_r <= cur_op.last;
                            nv_in = 1'b1;
                            gap_left = draw_gap(snd_streak);
                        end
                        OP_CFG: begin
                            cfg_data <= shop_ops[0].cfg;
                            nv_cfg = 1'b1;
                            void'(shop_ops.pop_front());
                        end
                        default: begin
                            // hold until every span is in and the chain has emptied
                            if (due_spans.size() != 0) begin
                                settle = 0;
                            end else if (settle >= SETTLE_CYCLES) begin
                                settle = 0;
                                void'(shop_ops.pop_front());
                            end else begin
                                settle++;
                            end
                        end
                    endcase
                end
            end
            in_valid <= nv_in;
            cfg_valid <= nv_cfg;
        end
    end

    always @(posedge clk) begin : collect_proc
        t_span want;
        int wait_left;
        int n_results;
        if (!rst_n) begin
            out_ready <= 1'b0;
            wait_left = 0;
            n_results = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_spans.size() == 0) begin
                    report_mismatch("span with none due (makespan)", 64'(makespan), 0);
                end else begin
                    want = due_spans.pop_front();
                    if (makespan !== want.makespan)
                        report_mismatch("makespan", 64'(makespan), 64'(want.makespan));
                    if (idle_total !== want.idle)
                        report_mismatch("idle_total", 64'(idle_total), 64'(want.idle));
                end
                n_results++;
                // long back-pressure now and then so the chain fills and stalls
                if (n_results % 64 == 20)
                    wait_left = HOLD_CYCLES;
                else
                    wait_left = draw_gap(rcv_streak);
            end else if (wait_left > 0) begin
                wait_left--;
            end
            out_ready <= (wait_left == 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int cfg_plan [10];
        int target;
        int len;
        int j;

        cfg_plan = '{2, 32, 0, 5, 63, 1, 33, 2, 12, 32};

        // directed: two machines, zero and full times, last mark on a write
        add_cfg(NMACH_W'(2));
        add_write(0, 0, '0, 1'b1);
        add_write(1, 0, '0, 1'b0);
        add_write(0, 255, '1, 1'b0);
        add_write(1, 255, '1, 1'b1);
        add_write(0, 1, PTIME_W'(3), 1'b0);
        add_write(1, 1, PTIME_W'(9), 1'b0);
        add_job(0, 1'b1);
        add_job(255, 1'b0);
        add_job(1, 1'b0);
        add_job(255, 1'b1);
        add_job(1, 1'b0);
        add_job(0, 1'b0);
        add_job(255, 1'b1);

        // all machines at full time: long runs of large sums
        add_cfg(NMACH_W'(32));
        for (int k = 0; k < NM; k++)
            add_write(k, 200, '1, 1'b0);
        for (int n = 0; n < 48; n++)
            add_job(200, n == 47);

        // random job sequences across machine counts
        target = n_items;
        for (int p = 0; p < 10; p++) begin
            add_cfg(NMACH_W'(cfg_plan[p]));
            target += 186;
            while (n_items < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_write($urandom_range(0, 31), $urandom_range(0, 255), rand_time(),
                              1'($urandom_range(0, 1)));
                end else begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        j = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 15);
                        // an unmarked tail now and then runs into the next sequence
                        add_ready_job(j, i == len - 1 && $urandom_range(0, 7) != 0);
                    end
                end
            end
            // leave a sequence open across the next machine-count change
            if (p == 3)
                add_ready_job($urandom_range(0, 15), 1'b0);
        end
        add_drain();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (shop_ops.size() != 0 || in_valid || cfg_valid || due_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
